// ===== src/rfr_pkg.sv =====
// rfr_pkg: shared types and constants of the remote frame receiver
// item payload structs, port mode codes, frame marker bytes, lane status struct
// no dependencies
package rfr_pkg;

	localparam int PORT_W    = 2;
	localparam int BYTE_W    = 8;
	localparam int MODE_W    = 2;
	localparam int POS_W     = 3;
	localparam int PAYLOAD_W = 3 * BYTE_W;

	// number of mode registers, one each for ports 0 to 2
	localparam int MODE_REGS = 3;

	// register indexes on the configuration channel
	localparam logic [PORT_W-1:0] REG_FIRST_MODE  = 2'd0;
	localparam logic [PORT_W-1:0] REG_SECOND_MODE = 2'd1;
	localparam logic [PORT_W-1:0] REG_THIRD_MODE  = 2'd2;

	// frame markers
	localparam logic [BYTE_W-1:0] FRAME_HEAD0 = 8'h0A;
	localparam logic [BYTE_W-1:0] FRAME_HEAD1 = 8'h03;
	localparam logic [BYTE_W-1:0] FRAME_HEAD2 = 8'hFC;
	localparam logic [BYTE_W-1:0] FRAME_TAIL  = 8'h0D;

	// frame positions: bytes of the frame matched so far
	localparam logic [POS_W-1:0] POS_HUNT  = 3'd0;
	localparam logic [POS_W-1:0] POS_HEAD1 = 3'd1;
	localparam logic [POS_W-1:0] POS_HEAD2 = 3'd2;
	localparam logic [POS_W-1:0] POS_PAY0  = 3'd3;
	localparam logic [POS_W-1:0] POS_PAY1  = 3'd4;
	localparam logic [POS_W-1:0] POS_PAY2  = 3'd5;
	localparam logic [POS_W-1:0] POS_TAIL  = 3'd6;

	// port modes; code 3 behaves as off
	typedef enum logic [MODE_W-1:0] {
		MODE_OFF   = 2'd0,
		MODE_RAW   = 2'd1,
		MODE_FRAME = 2'd2
	} mode_t;

	// result kinds
	localparam logic KIND_RAW   = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	typedef struct packed {
		logic [PORT_W-1:0] port_number;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [PORT_W-1:0] out_port;
		logic              out_kind;
		logic [BYTE_W-1:0] data_first;
		logic [BYTE_W-1:0] data_second;
		logic [BYTE_W-1:0] data_third;
	} out_item_t;

	// status of one port lane for the item in flight
	typedef struct packed {
		logic                 done;
		logic [PAYLOAD_W-1:0] payload;
	} lane_res_t;

endpackage

// ===== src/rfr_if.sv =====
// rfr_if: valid/ready channel interfaces of the remote frame receiver
// input byte channel, result channel and configuration write channel
// depends on rfr_pkg
interface rfr_in_if;
	import rfr_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

interface rfr_out_if;
	import rfr_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

interface rfr_cfg_if;
	import rfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [PORT_W-1:0] index;
	logic [MODE_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/rfr_lane.sv =====
// rfr_lane: frame hunt state of one serial port
// frame position counter and payload shift register, updated once per hit
// depends on rfr_pkg
module rfr_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      hit,
	input  logic [rfr_pkg::BYTE_W-1:0] rx_byte,
	output rfr_pkg::lane_res_t         res
);
	import rfr_pkg::*;

	logic [POS_W-1:0]     pos_q, pos_d;
	logic [PAYLOAD_W-1:0] hold_q, hold_d;

	always_comb begin
		pos_d  = pos_q;
		hold_d = hold_q;
		case (pos_q) inside
			POS_HEAD1: begin
				if (rx_byte == FRAME_HEAD1) begin
					pos_d = POS_HEAD2;
				end else begin
					pos_d  = POS_HUNT;
					hold_d = '0;
				end
			end
			POS_HEAD2: begin
				if (rx_byte == FRAME_HEAD2) begin
					pos_d = POS_PAY0;
				end else begin
					pos_d  = POS_HUNT;
					hold_d = '0;
				end
			end
			POS_PAY0, POS_PAY1, POS_PAY2: begin
				hold_d = {hold_q[PAYLOAD_W-BYTE_W-1:0], rx_byte};
				pos_d  = pos_q + POS_W'(1);
			end
			POS_TAIL: begin
				// frame ends here whether or not the trailer matches
				pos_d  = POS_HUNT;
				hold_d = '0;
			end
			default: begin
				// hunting, also the unreachable position 7
				hold_d = '0;
				pos_d  = (rx_byte == FRAME_HEAD0) ? POS_HEAD1 : POS_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HUNT;
			hold_q <= '0;
		end else if (hit) begin
			pos_q  <= pos_d;
			hold_q <= hold_d;
		end
	end

	assign res.done    = hit && (pos_q == POS_TAIL) && (rx_byte == FRAME_TAIL);
	assign res.payload = hold_q;

endmodule

// ===== src/remote_frame_receiver.sv =====
// remote_frame_receiver: top level of the remote frame receiver
// input register, per-port mode decode and frame lanes, result register
// depends on rfr_pkg, rfr_if (rfr_in_if, rfr_out_if, rfr_cfg_if), rfr_lane
//
//  channel  direction  handshake     payload
//  rx_in    sink       valid/ready   port_number, rx_byte
//  res_out  source     valid/ready   out_port, out_kind, data_first..data_third
//  cfg      sink       valid/ready   index (mode register), data (mode code)
//
// one item per cycle while the result side is not stalled: an accepted item sits in the
// input register, the mode decode and the port's frame lane settle it, and any result
// lands in the result register when the input register advances
// frame state is read and written in the input-register stage, so consecutive
// bytes of one port see each other's updates with no bubble
// arst_n clears modes, frame state and both valid flags; cfg is always ready
// a stalled result holds the input register, and rx_in stalls only behind it
module remote_frame_receiver #(
	parameter int PORT_COUNT = 3
) (
	input  logic     clk,
	input  logic     arst_n,
	rfr_in_if.sink   rx_in,
	rfr_out_if.source res_out,
	rfr_cfg_if.sink  cfg
);
	import rfr_pkg::*;

	// ports that have both a mode register and frame state
	localparam int LANES = (PORT_COUNT < MODE_REGS) ? PORT_COUNT : MODE_REGS;

	// configuration registers
	mode_t mode_q [MODE_REGS];

	// input register stage
	logic     valid_s1;
	in_item_t item_s1;

	// result register stage
	logic      res_valid_s2;
	out_item_t res_s2;

	logic      res_free;
	logic      in_ready;
	logic      adv;
	logic      port_ok;
	mode_t     cur_mode;
	logic      res_hit;
	out_item_t res_d;
	logic      frame_done;
	logic [PAYLOAD_W-1:0] frame_payload;

	lane_res_t lane_res [LANES];

	// mode registers; writes beyond the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MODE_REGS; i++) begin
				mode_q[i] <= MODE_OFF;
			end
		end else if (cfg.valid) begin
			for (int i = 0; i < MODE_REGS; i++) begin
				if (cfg.index == PORT_W'(i)) begin
					mode_q[i] <= mode_t'(cfg.data);
				end
			end
		end
	end

	// handshake: input register moves whenever the result register can take
	assign res_free = !res_valid_s2 || res_out.ready;
	assign in_ready = !valid_s1 || res_free;
	assign adv      = valid_s1 && res_free;
	assign rx_in.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= rx_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && rx_in.valid) begin
			item_s1 <= rx_in.item;
		end
	end

	// mode of the item's port; ports without a register or lane count as off
	always_comb begin
		port_ok  = (int'(item_s1.port_number) < LANES);
		cur_mode = MODE_OFF;
		for (int i = 0; i < LANES; i++) begin
			if (item_s1.port_number == PORT_W'(i)) begin
				cur_mode = mode_q[i];
			end
		end
	end

	// one lane per port keeps that port's frame hunt
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic lane_hit;
		assign lane_hit = adv && port_ok && (item_s1.port_number == PORT_W'(g))
			&& (mode_q[g] == MODE_FRAME);
		rfr_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.hit    (lane_hit),
			.rx_byte(item_s1.rx_byte),
			.res    (lane_res[g])
		);
	end

	// only the addressed lane can report a finished frame
	always_comb begin
		frame_done    = 1'b0;
		frame_payload = '0;
		for (int i = 0; i < LANES; i++) begin
			frame_done    = frame_done | lane_res[i].done;
			frame_payload = frame_payload | (lane_res[i].done ? lane_res[i].payload : '0);
		end
	end

	// result for the item in the input register
	always_comb begin
		res_d.out_port    = item_s1.port_number;
		res_d.out_kind    = KIND_RAW;
		res_d.data_first  = item_s1.rx_byte;
		res_d.data_second = '0;
		res_d.data_third  = '0;
		res_hit           = 1'b0;
		case (cur_mode)
			MODE_RAW: begin
				res_hit = port_ok;
			end
			MODE_FRAME: begin
				res_hit           = frame_done;
				res_d.out_kind    = KIND_FRAME;
				res_d.data_first  = frame_payload[PAYLOAD_W-1 -: BYTE_W];
				res_d.data_second = frame_payload[2*BYTE_W-1 -: BYTE_W];
				res_d.data_third  = frame_payload[BYTE_W-1:0];
			end
			default: begin
				res_hit = 1'b0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (res_free) begin
			res_valid_s2 <= adv && res_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_hit) begin
			res_s2 <= res_d;
		end
	end

	assign res_out.valid = res_valid_s2;
	assign res_out.item  = res_s2;

endmodule

// ===== src/rfr_checker.sv =====
// rfr_checker: port-level assertions for the remote frame receiver
// watches the input and result channels only, bound to the top level below
// depends on rfr_pkg
module rfr_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input rfr_pkg::out_item_t   out_item
);
	import rfr_pkg::*;

	// raw results carry zeros in the upper data fields
	a_raw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.out_kind == KIND_RAW) |->
		(out_item.data_second == '0) && (out_item.data_third == '0))
		else $error("raw result with nonzero upper data");

	// a new result rises only after an accepted item has passed the input and result registers
	a_rise_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching accepted item");

	// input backs up only behind a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while result side is free");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

endmodule

bind remote_frame_receiver rfr_checker u_rfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (rx_in.valid),
	.in_ready (rx_in.ready),
	.out_valid(res_out.valid),
	.out_ready(res_out.ready),
	.out_item (res_out.item)
);

// ===== bench/tb.sv =====
// tb: self-checking testbench of remote_frame_receiver, per-port raw and frame modes
// a directed table of bytes and mode writes, then random phases checked against a predictor
// depends on rfr_pkg, rfr_if and remote_frame_receiver
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rfr_pkg::*;

	localparam int NPORTS = 3;
	// codes the package leaves unnamed: a register index with no register,
	// a port number with no port and the spare mode code
	localparam logic [PORT_W-1:0] REG_UNMAPPED = 2'd3;
	localparam logic [PORT_W-1:0] PORT_UNWIRED = 2'd3;
	localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

	localparam int TARGET_ITEMS  = 1500;
	localparam int PHASE_ITEMS   = 100;
	localparam int SETTLE_CYCLES = 4;    // input and result registers plus margin
	localparam int HOLD_CYCLES   = 120;

	// one row of the directed table: a mode write or a byte, with an optional
	// hand-typed result that replaces the predicted one
	typedef struct {
		bit                is_cfg;
		logic [PORT_W-1:0] sel;
		logic [BYTE_W-1:0] value;
		bit                typed;
		out_item_t         want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rfr_in_if  rx_bus();
	rfr_out_if res_bus();
	rfr_cfg_if cfg_bus();

	remote_frame_receiver #(.PORT_COUNT(NPORTS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx_in  (rx_bus),
		.res_out(res_bus),
		.cfg    (cfg_bus)
	);

	// predictor state: mode registers and the frame hunt of each port
	logic [MODE_W-1:0]    mode_of   [MODE_REGS];
	logic [POS_W-1:0]     frame_pos [NPORTS];
	logic [PAYLOAD_W-1:0] payload   [NPORTS];

	out_item_t pending_results[$];
	step_t     plan[$];
	// bytes queued per port; frames here survive mode changes on purpose
	logic [BYTE_W-1:0] backlog [4][$];

	int mismatches    = 0;
	int items_sent    = 0;
	int items_counted = 0;
	int results_seen  = 0;
	int frames_seen   = 0;
	int cfg_writes    = 0;
	int phases        = 0;

	bit steady_send  = 1'b0;
	bit steady_take  = 1'b0;
	bit hold_request = 1'b0;
	int hold_left    = 0;

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic void drop_frame(input int unsigned p);
		frame_pos[p] = POS_HUNT;
		payload[p]   = '0;
	endfunction

	// advance the predictor by one byte; returns 1 when the byte yields a result
	function automatic bit decode_byte(input in_item_t it, output out_item_t res);
		int unsigned p;
		logic [BYTE_W-1:0] b;
		res = '0;
		p   = it.port_number;
		b   = it.rx_byte;
		// ports past the register file are dropped silently
		if (p >= MODE_REGS || p >= NPORTS)
			return 1'b0;
		if (mode_of[p] == MODE_RAW) begin
			res.out_port   = it.port_number;
			res.out_kind   = KIND_RAW;
			res.data_first = b;
			return 1'b1;
		end
		// off and the spare code both ignore the byte
		if (mode_of[p] != MODE_FRAME)
			return 1'b0;
		case (frame_pos[p])
			POS_HEAD1: begin
				if (b == FRAME_HEAD1) frame_pos[p] = POS_HEAD2;
				else drop_frame(p);
			end
			POS_HEAD2: begin
				if (b == FRAME_HEAD2) frame_pos[p] = POS_PAY0;
				else drop_frame(p);
			end
			POS_PAY0, POS_PAY1, POS_PAY2: begin
				payload[p]   = {payload[p][PAYLOAD_W-BYTE_W-1:0], b};
				frame_pos[p] = frame_pos[p] + 1'b1;
			end
			POS_TAIL: begin
				if (b == FRAME_TAIL) begin
					res.out_port    = it.port_number;
					res.out_kind    = KIND_FRAME;
					res.data_first  = payload[p][23:16];
					res.data_second = payload[p][15:8];
					res.data_third  = payload[p][7:0];
					drop_frame(p);
					return 1'b1;
				end
				drop_frame(p);
			end
			// hunting; the unreachable position 7 lands here as well
			default: begin
				payload[p]   = '0;
				frame_pos[p] = (b == FRAME_HEAD0) ? POS_HEAD1 : POS_HUNT;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic out_item_t mk_result(input logic [PORT_W-1:0] p, input logic k,
			input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
			input logic [BYTE_W-1:0] c);
		out_item_t r;
		r.out_port    = p;
		r.out_kind    = k;
		r.data_first  = a;
		r.data_second = b;
		r.data_third  = c;
		return r;
	endfunction

	function automatic void put(input bit is_cfg, input logic [PORT_W-1:0] sel,
			input logic [BYTE_W-1:0] value, input bit typed, input out_item_t want);
		step_t s;
		s.is_cfg = is_cfg;
		s.sel    = sel;
		s.value  = value;
		s.typed  = typed;
		s.want   = want;
		plan.push_back(s);
	endfunction

	// half of the draws land on a frame marker so the hunt gets exercised
	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(7))
			0: return FRAME_HEAD0;
			1: return FRAME_HEAD1;
			2: return FRAME_HEAD2;
			3: return FRAME_TAIL;
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	// queue more bytes for one port: mostly whole frames when it decodes,
	// some frames with one byte broken, and loose bytes
	function automatic void refill(input int p);
		logic [BYTE_W-1:0] f [7];
		int r;
		r = $urandom_range(99);
		if (p < MODE_REGS && mode_of[p] == MODE_FRAME && r < 85) begin
			f[0] = FRAME_HEAD0;
			f[1] = FRAME_HEAD1;
			f[2] = FRAME_HEAD2;
			f[3] = pick_byte();
			f[4] = BYTE_W'($urandom_range(255));
			f[5] = pick_byte();
			f[6] = FRAME_TAIL;
			if (r >= 65)
				f[$urandom_range(6)] = pick_byte();
			foreach (f[k])
				backlog[p].push_back(f[k]);
		end else begin
			backlog[p].push_back(pick_byte());
		end
	endfunction

	// offer one byte, wait for the handshake, then predict what it causes
	task automatic offer_byte(input logic [PORT_W-1:0] p, input logic [BYTE_W-1:0] b,
			input bit typed, input out_item_t want);
		in_item_t  it;
		out_item_t res;
		bit        got;
		it.port_number = p;
		it.rx_byte     = b;
		while (!steady_send && $urandom_range(99) < 34) begin
			rx_bus.valid <= 1'b0;
			@(posedge clk);
		end
		rx_bus.valid <= 1'b1;
		rx_bus.item  <= it;
		do @(posedge clk); while (rx_bus.ready !== 1'b1);
		items_sent++;
		if (p < MODE_REGS && (mode_of[p] == MODE_RAW || mode_of[p] == MODE_FRAME))
			items_counted++;
		got = decode_byte(it, res);
		if (typed)
			pending_results.push_back(want);
		else if (got)
			pending_results.push_back(res);
	endtask

	// stop offering, drain every expected result, then let trailing bytes
	// that produce nothing clear the pipeline
	task automatic settle();
		rx_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [PORT_W-1:0] idx, input logic [MODE_W-1:0] m);
		settle();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= m;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		cfg_writes++;
		// an index past the register file writes nothing
		if (idx < MODE_REGS)
			mode_of[idx] = m;
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		results_seen++;
		if (got.out_kind === KIND_FRAME)
			frames_seen++;
		if (pending_results.size() == 0) begin
			flag_mismatch($sformatf("result %h with nothing expected", got));
			return;
		end
		want = pending_results.pop_front();
		if (got.out_port !== want.out_port)
			flag_mismatch($sformatf("out_port %h, expected %h", got.out_port, want.out_port));
		if (got.out_kind !== want.out_kind)
			flag_mismatch($sformatf("out_kind %h, expected %h", got.out_kind, want.out_kind));
		if (got.data_first !== want.data_first)
			flag_mismatch($sformatf("data_first %h, expected %h",
				got.data_first, want.data_first));
		if (got.data_second !== want.data_second)
			flag_mismatch($sformatf("data_second %h, expected %h",
				got.data_second, want.data_second));
		if (got.data_third !== want.data_third)
			flag_mismatch($sformatf("data_third %h, expected %h",
				got.data_third, want.data_third));
	endtask

	// result side: check each accepted item, then pick ready for the next edge;
	// a long hold is counted down here while the sender keeps offering
	initial begin
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
				check_result(res_bus.item);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else if (steady_take) begin
				res_bus.ready <= 1'b1;
			end else begin
				res_bus.ready <= ($urandom_range(99) >= 34);
			end
		end
	end

	// stimulus
	initial begin
		logic [PORT_W-1:0] p;
		logic [MODE_W-1:0] m;
		int r;

		arst_n        <= 1'b0;
		rx_bus.valid  <= 1'b0;
		rx_bus.item   <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= '0;
		cfg_bus.data  <= '0;
		for (int i = 0; i < MODE_REGS; i++)
			mode_of[i] = MODE_OFF;
		for (int i = 0; i < NPORTS; i++) begin
			frame_pos[i] = POS_HUNT;
			payload[i]   = '0;
		end

		// after reset every port is off: nothing comes out
		put(1'b0, 2'd0, 8'h00, 1'b0, '0);
		put(1'b0, 2'd1, 8'hFF, 1'b0, '0);
		put(1'b0, 2'd2, FRAME_HEAD0, 1'b0, '0);
		put(1'b0, PORT_UNWIRED, 8'h55, 1'b0, '0);
		// port 0 raw, port 1 frame, port 2 on the spare code, and a write
		// to an index with no register behind it
		put(1'b1, REG_FIRST_MODE, MODE_RAW, 1'b0, '0);
		put(1'b1, REG_SECOND_MODE, MODE_FRAME, 1'b0, '0);
		put(1'b1, REG_THIRD_MODE, MODE_SPARE, 1'b0, '0);
		put(1'b1, REG_UNMAPPED, MODE_RAW, 1'b0, '0);
		// raw byte extremes
		put(1'b0, 2'd0, 8'h00, 1'b1, mk_result(2'd0, KIND_RAW, 8'h00, 8'h00, 8'h00));
		put(1'b0, 2'd0, 8'hFF, 1'b1, mk_result(2'd0, KIND_RAW, 8'hFF, 8'h00, 8'h00));
		// the spare mode code stays silent
		put(1'b0, 2'd2, 8'hAA, 1'b0, '0);
		// one clean frame with payload extremes
		put(1'b0, 2'd1, FRAME_HEAD0, 1'b0, '0);
		put(1'b0, 2'd1, FRAME_HEAD1, 1'b0, '0);
		put(1'b0, 2'd1, FRAME_HEAD2, 1'b0, '0);
		put(1'b0, 2'd1, 8'h00, 1'b0, '0);
		put(1'b0, 2'd1, 8'hFF, 1'b0, '0);
		put(1'b0, 2'd1, 8'h5A, 1'b0, '0);
		put(1'b0, 2'd1, FRAME_TAIL, 1'b1, mk_result(2'd1, KIND_FRAME, 8'h00, 8'hFF, 8'h5A));
		// repeated header: the mismatching byte is not retried as a header
		put(1'b0, 2'd1, FRAME_HEAD0, 1'b0, '0);
		put(1'b0, 2'd1, FRAME_HEAD0, 1'b0, '0);
		put(1'b0, 2'd1, FRAME_HEAD1, 1'b0, '0);
		put(1'b0, 2'd1, FRAME_HEAD2, 1'b0, '0);
		// bad trailer drops the whole frame
		put(1'b0, 2'd1, FRAME_HEAD0, 1'b0, '0);
		put(1'b0, 2'd1, FRAME_HEAD1, 1'b0, '0);
		put(1'b0, 2'd1, FRAME_HEAD2, 1'b0, '0);
		put(1'b0, 2'd1, 8'h01, 1'b0, '0);
		put(1'b0, 2'd1, 8'h02, 1'b0, '0);
		put(1'b0, 2'd1, 8'h03, 1'b0, '0);
		put(1'b0, 2'd1, 8'h0E, 1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[s]) begin
			if (plan[s].is_cfg)
				write_mode(plan[s].sel, plan[s].value[MODE_W-1:0]);
			else
				offer_byte(plan[s].sel, plan[s].value, plan[s].typed, plan[s].want);
		end

		// random phases: the first few pin every port to one mode, the rest mix
		while (items_sent < TARGET_ITEMS) begin
			for (int i = 0; i < MODE_REGS; i++) begin
				case (phases)
					0: m = MODE_FRAME;
					1: m = MODE_RAW;
					2: m = MODE_OFF;
					3: m = MODE_SPARE;
					default: begin
						r = $urandom_range(99);
						m = (r < 50) ? MODE_FRAME : (r < 75) ? MODE_RAW :
							(r < 88) ? MODE_OFF : MODE_SPARE;
					end
				endcase
				write_mode(i[PORT_W-1:0], m);
			end
			if ($urandom_range(3) == 0)
				write_mode(REG_UNMAPPED, MODE_W'($urandom_range(3)));

			// all-raw phase: receiver holds off so the block backs up;
			// phase four runs with no idling on either side
			steady_send = (phases == 1 || phases == 4);
			steady_take = (phases == 4);
			if (phases == 1)
				hold_request = 1'b1;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				p = ($urandom_range(99) < 3) ? PORT_UNWIRED : PORT_W'($urandom_range(NPORTS - 1));
				if (backlog[p].size() == 0)
					refill(p);
				offer_byte(p, backlog[p].pop_front(), 1'b0, '0);
			end
			phases++;
		end

		steady_send = 1'b0;
		steady_take = 1'b0;
		settle();
		$display("covered %0d bytes (%0d on live ports) over %0d mode settings, %0d mode writes",
			items_sent, items_counted, phases, cfg_writes);
		$display("checked %0d results, %0d of them decoded frames", results_seen, frames_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rfr_pkg.sv
src/rfr_if.sv
src/rfr_lane.sv
src/remote_frame_receiver.sv
src/rfr_checker.sv
bench/tb.sv
